// File: rtl/pngcp_pkg.sv
`default_nettype none

package pngcp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 32;
  localparam int unsigned IdxW  = 3;

  localparam logic [WordW-1:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [WordW-1:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [WordW-1:0] TYPE_IEND = 32'h4945_4E44;

  localparam logic [IdxW-1:0] IDX_SIG_LAST   = 3'd7;
  localparam logic [IdxW-1:0] IDX_FIELD_LAST = 3'd3;

  localparam logic [1:0] KIND_MSG = 2'd0;
  localparam logic [1:0] KIND_SUM = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  typedef enum logic [5:0] {
    PH_SIG  = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_TYPE = 6'b000100,
    PH_DATA = 6'b001000,
    PH_CRC  = 6'b010000,
    PH_DONE = 6'b100000
  } phase_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       kind;
    logic [ByteW-1:0] message_byte;
    logic [WordW-1:0] chunk_length;
    logic [WordW-1:0] type_word;
    logic [WordW-1:0] crc_word;
    logic             known_type;
    logic             final_chunk;
  } result_t;

  function automatic logic [ByteW-1:0] sig_byte(input logic [IdxW-1:0] idx);
    logic [ByteW-1:0] b;
    case (idx)
      3'd0:    b = 8'd137;
      3'd1:    b = 8'd80;
      3'd2:    b = 8'd78;
      3'd3:    b = 8'd71;
      3'd4:    b = 8'd13;
      3'd5:    b = 8'd10;
      3'd6:    b = 8'd26;
      default: b = 8'd10;
    endcase
    return b;
  endfunction

  function automatic logic is_known(input logic [WordW-1:0] t);
    return (t == TYPE_IHDR) || (t == TYPE_IDAT) || (t == TYPE_IEND);
  endfunction

endpackage

`default_nettype wire

// File: rtl/pngcp_in_reg.sv
`default_nettype none

module pngcp_in_reg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [pngcp_pkg::ByteW-1:0]  in_byte,
  input  wire logic                         advance,
  output logic                              held_valid,
  output logic [pngcp_pkg::ByteW-1:0]       held_byte
);
  import pngcp_pkg::*;

  // Hold the request while the parse stage cannot move.
  assign in_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      held_byte <= in_byte;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pngcp_parse.sv
`default_nettype none

module pngcp_parse (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         step,
  input  wire logic [pngcp_pkg::ByteW-1:0]  byte_in,
  input  wire logic                         emit_message_bytes,
  output pngcp_pkg::result_t                res
);
  import pngcp_pkg::*;

  phase_t           phase, phase_next;
  logic [IdxW-1:0]  idx, idx_next;
  logic [WordW-1:0] length_reg, length_reg_next;
  logic [WordW-1:0] remaining, remaining_next;
  logic [WordW-1:0] type_reg, type_reg_next;
  logic [WordW-1:0] crc_reg, crc_reg_next;
  logic             mismatch, mismatch_next;

  logic [WordW-1:0] type_shift;
  logic [WordW-1:0] crc_shift;

  assign type_shift = {type_reg[WordW-ByteW-1:0], byte_in};
  assign crc_shift  = {crc_reg[WordW-ByteW-1:0], byte_in};

  always_comb begin
    phase_next      = phase;
    idx_next        = idx;
    length_reg_next = length_reg;
    remaining_next  = remaining;
    type_reg_next   = type_reg;
    crc_reg_next    = crc_reg;
    mismatch_next   = mismatch;
    res             = '0;

    case (phase)
      PH_SIG: begin
        mismatch_next = mismatch || (byte_in != sig_byte(idx));
        if (idx == IDX_SIG_LAST) begin
          idx_next = '0;
          if (mismatch_next) begin
            phase_next = PH_DONE;
            res.valid  = 1'b1;
            res.kind   = KIND_ERR;
          end else begin
            phase_next = PH_LEN;
          end
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      PH_LEN: begin
        length_reg_next = {length_reg[WordW-ByteW-1:0], byte_in};
        if (idx == IDX_FIELD_LAST) begin
          idx_next   = '0;
          phase_next = PH_TYPE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      PH_TYPE: begin
        type_reg_next = type_shift;
        if (idx == IDX_FIELD_LAST) begin
          idx_next       = '0;
          remaining_next = length_reg;
          phase_next     = (length_reg == '0) ? PH_CRC : PH_DATA;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      PH_DATA: begin
        remaining_next = remaining - 1'b1;
        if (remaining_next == '0) begin
          phase_next = PH_CRC;
        end
        if (emit_message_bytes && !is_known(type_reg)) begin
          res.valid        = 1'b1;
          res.kind         = KIND_MSG;
          res.message_byte = byte_in;
        end
      end
      PH_CRC: begin
        crc_reg_next = crc_shift;
        if (idx == IDX_FIELD_LAST) begin
          idx_next         = '0;
          res.valid        = 1'b1;
          res.kind         = KIND_SUM;
          res.chunk_length = length_reg;
          res.type_word    = type_reg;
          res.crc_word     = crc_shift;
          res.known_type   = is_known(type_reg);
          res.final_chunk  = (type_reg == TYPE_IEND);
          // Clear the shift registers for the next chunk.
          length_reg_next  = '0;
          type_reg_next    = '0;
          crc_reg_next     = '0;
          phase_next       = (type_reg == TYPE_IEND) ? PH_DONE : PH_LEN;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      default: begin
        // Done: drop every byte.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SIG;
      idx        <= '0;
      length_reg <= '0;
      remaining  <= '0;
      type_reg   <= '0;
      crc_reg    <= '0;
      mismatch   <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      idx        <= idx_next;
      length_reg <= length_reg_next;
      remaining  <= remaining_next;
      type_reg   <= type_reg_next;
      crc_reg    <= crc_reg_next;
      mismatch   <= mismatch_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pngcp_out_reg.sv
`default_nettype none

module pngcp_out_reg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         step,
  input  wire pngcp_pkg::result_t           res,
  input  wire logic                         out_stall,
  output logic                              advance,
  output logic                              out_valid,
  output logic [1:0]                        kind,
  output logic [pngcp_pkg::ByteW-1:0]       message_byte,
  output logic [pngcp_pkg::WordW-1:0]       chunk_length,
  output logic [pngcp_pkg::WordW-1:0]       type_word,
  output logic [pngcp_pkg::WordW-1:0]       crc_word,
  output logic                              known_type,
  output logic                              final_chunk
);
  import pngcp_pkg::*;

  // Move on whenever the result register is empty or being taken.
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step && res.valid) begin
      kind         <= res.kind;
      message_byte <= res.message_byte;
      chunk_length <= res.chunk_length;
      type_word    <= res.type_word;
      crc_word     <= res.crc_word;
      known_type   <= res.known_type;
      final_chunk  <= res.final_chunk;
    end
  end

endmodule

`default_nettype wire

// File: rtl/png_chunk_stream_parser.sv
// Flow: a byte accepted is held in the input register, parsed combinationally, and its
// result is written into the output register, from which it can be taken.
// Throughput: one byte per cycle while no stalled result blocks the parser; the output
// register and the input register let a new byte enter while a finished result waits.
// Reset (rst, synchronous, active high): signature phase, chunk registers cleared,
// no result pending, emit_message_bytes set to 1.
`default_nettype none

module png_chunk_stream_parser (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [pngcp_pkg::ByteW-1:0]  in_byte,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        kind,
  output logic [pngcp_pkg::ByteW-1:0]       message_byte,
  output logic [pngcp_pkg::WordW-1:0]       chunk_length,
  output logic [pngcp_pkg::WordW-1:0]       type_word,
  output logic [pngcp_pkg::WordW-1:0]       crc_word,
  output logic                              known_type,
  output logic                              final_chunk,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic                         cfg_data
);
  import pngcp_pkg::*;

  logic             emit_message_bytes;
  logic             advance;
  logic             held_valid;
  logic [ByteW-1:0] held_byte;
  logic             step;
  result_t          res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_message_bytes <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      emit_message_bytes <= cfg_data;
    end
  end

  assign step = held_valid && advance;

  pngcp_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  pngcp_parse u_parse (
    .clk                (clk),
    .rst                (rst),
    .step               (step),
    .byte_in            (held_byte),
    .emit_message_bytes (emit_message_bytes),
    .res                (res)
  );

  pngcp_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .res          (res),
    .out_stall    (out_stall),
    .advance      (advance),
    .out_valid    (out_valid),
    .kind         (kind),
    .message_byte (message_byte),
    .chunk_length (chunk_length),
    .type_word    (type_word),
    .crc_word     (crc_word),
    .known_type   (known_type),
    .final_chunk  (final_chunk)
  );

endmodule

`default_nettype wire

// File: rtl/pngcp_checker.sv
`default_nettype none

module pngcp_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [1:0]                   kind,
  input wire logic [pngcp_pkg::ByteW-1:0]  message_byte,
  input wire logic [pngcp_pkg::WordW-1:0]  chunk_length,
  input wire logic [pngcp_pkg::WordW-1:0]  type_word,
  input wire logic [pngcp_pkg::WordW-1:0]  crc_word,
  input wire logic                         known_type,
  input wire logic                         final_chunk
);
  import pngcp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(crc_word))
    else $error("stalled result changed");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_MSG) || (kind == KIND_SUM) || (kind == KIND_ERR))
    else $error("result kind out of range");

  a_msg_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_MSG |-> chunk_length == '0 && type_word == '0 &&
      crc_word == '0 && !known_type && !final_chunk)
    else $error("message request carries summary fields");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERR |-> message_byte == '0 && chunk_length == '0 &&
      type_word == '0 && crc_word == '0 && !known_type && !final_chunk)
    else $error("error request carries data");

  a_final_known: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_SUM && final_chunk |-> known_type &&
      type_word == TYPE_IEND && message_byte == '0)
    else $error("final summary without end type");

endmodule

bind png_chunk_stream_parser pngcp_checker u_pngcp_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .kind         (kind),
  .message_byte (message_byte),
  .chunk_length (chunk_length),
  .type_word    (type_word),
  .crc_word     (crc_word),
  .known_type   (known_type),
  .final_chunk  (final_chunk)
);

`default_nettype wire

// File: tb/png_chunk_stream_parser_checker.sv
module png_chunk_stream_parser_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic [pngcp_pkg::ByteW-1:0] in_byte,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic [1:0]                  kind,
  input  wire logic [pngcp_pkg::ByteW-1:0] message_byte,
  input  wire logic [pngcp_pkg::WordW-1:0] chunk_length,
  input  wire logic [pngcp_pkg::WordW-1:0] type_word,
  input  wire logic [pngcp_pkg::WordW-1:0] crc_word,
  input  wire logic                        known_type,
  input  wire logic                        final_chunk,
  input  wire logic                        cfg_valid,
  input  wire logic                        cfg_ready,
  input  wire logic                        cfg_data,
  output int                               fails,
  output int                               waiting,
  output int                               msg_total,
  output int                               summary_total,
  output int                               error_total
);
  timeunit 1ns;
  timeprecision 1ps;
  import pngcp_pkg::*;

  localparam logic [63:0] PNG_MAGIC = 64'h8950_4E47_0D0A_1A0A;

  typedef struct packed {
    logic [1:0]       kind;
    logic [ByteW-1:0] msg;
    logic [WordW-1:0] len;
    logic [WordW-1:0] typ;
    logic [WordW-1:0] crc;
    logic             known;
    logic             fin;
  } chunk_record_t;

  chunk_record_t parsed_q[$];

  phase_t           ph;
  logic [IdxW-1:0]  idx;
  logic [WordW-1:0] len_acc;
  logic [WordW-1:0] left;
  logic [WordW-1:0] typ_acc;
  logic [WordW-1:0] crc_acc;
  logic             bad_sig;
  logic             emit;
  int               fail_n;
  int               n_msg;
  int               n_sum;
  int               n_err;

  initial begin
    fail_n = 0;
    n_msg = 0;
    n_sum = 0;
    n_err = 0;
  end

  function automatic logic standard_type(input logic [WordW-1:0] t);
    return t == TYPE_IHDR || t == TYPE_IDAT || t == TYPE_IEND;
  endfunction

  task automatic parse_png_byte(input logic [ByteW-1:0] b);
    chunk_record_t rec;
    logic          fin;
    rec = '0;
    case (ph)
      PH_SIG: begin
        if (b != PNG_MAGIC[63 - 8*idx -: 8]) bad_sig = 1'b1;
        if (idx >= IDX_SIG_LAST) begin
          idx = '0;
          if (bad_sig) begin
            ph = PH_DONE;
            rec.kind = KIND_ERR;
            parsed_q.push_back(rec);
          end else begin
            ph = PH_LEN;
          end
        end else begin
          idx = idx + 1'b1;
        end
      end
      PH_LEN: begin
        len_acc = {len_acc[WordW-9:0], b};
        if (idx >= IDX_FIELD_LAST) begin
          idx = '0;
          ph = PH_TYPE;
        end else begin
          idx = idx + 1'b1;
        end
      end
      PH_TYPE: begin
        typ_acc = {typ_acc[WordW-9:0], b};
        if (idx >= IDX_FIELD_LAST) begin
          idx = '0;
          left = len_acc;
          ph = (len_acc == '0) ? PH_CRC : PH_DATA;
        end else begin
          idx = idx + 1'b1;
        end
      end
      PH_DATA: begin
        left = left - 1'b1;
        if (left == '0) ph = PH_CRC;
        if (emit && !standard_type(typ_acc)) begin
          rec.kind = KIND_MSG;
          rec.msg = b;
          parsed_q.push_back(rec);
        end
      end
      PH_CRC: begin
        crc_acc = {crc_acc[WordW-9:0], b};
        if (idx >= IDX_FIELD_LAST) begin
          fin = (typ_acc == TYPE_IEND);
          idx = '0;
          rec.kind = KIND_SUM;
          rec.len = len_acc;
          rec.typ = typ_acc;
          rec.crc = crc_acc;
          rec.known = standard_type(typ_acc);
          rec.fin = fin;
          parsed_q.push_back(rec);
          len_acc = '0;
          typ_acc = '0;
          crc_acc = '0;
          ph = fin ? PH_DONE : PH_LEN;
        end else begin
          idx = idx + 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    chunk_record_t got;
    chunk_record_t want;
    if (rst) begin
      ph = PH_SIG;
      idx = '0;
      len_acc = '0;
      left = '0;
      typ_acc = '0;
      crc_acc = '0;
      bad_sig = 1'b0;
      emit = 1'b1;
      parsed_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) emit = cfg_data;
      if (in_valid && !in_stall) parse_png_byte(in_byte);
      if (out_valid && !out_stall) begin
        got.kind = kind;
        got.msg = message_byte;
        got.len = chunk_length;
        got.typ = type_word;
        got.crc = crc_word;
        got.known = known_type;
        got.fin = final_chunk;
        case (got.kind)
          KIND_MSG: n_msg++;
          KIND_SUM: n_sum++;
          default:  n_err++;
        endcase
        if (parsed_q.size() == 0) begin
          if (fail_n < 10)
            $display("%0t: unexpected result kind=%0d msg=%h len=%h type=%h crc=%h",
                     $realtime, got.kind, got.msg, got.len, got.typ, got.crc);
          fail_n++;
        end else begin
          want = parsed_q.pop_front();
          if (got.kind !== want.kind || got.msg !== want.msg || got.len !== want.len ||
              got.typ !== want.typ || got.crc !== want.crc || got.known !== want.known ||
              got.fin !== want.fin) begin
            if (fail_n < 10) begin
              $display("%0t: mismatch exp kind=%0d msg=%h len=%h type=%h crc=%h known=%b fin=%b",
                       $realtime, want.kind, want.msg, want.len, want.typ, want.crc,
                       want.known, want.fin);
              $display("%0t:          got kind=%0d msg=%h len=%h type=%h crc=%h known=%b fin=%b",
                       $realtime, got.kind, got.msg, got.len, got.typ, got.crc,
                       got.known, got.fin);
            end
            fail_n++;
          end
        end
      end
    end
    fails <= fail_n;
    waiting <= parsed_q.size();
    msg_total <= n_msg;
    summary_total <= n_sum;
    error_total <= n_err;
  end

endmodule

// File: tb/png_chunk_stream_parser_test.sv
module png_chunk_stream_parser_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pngcp_pkg::*;

  localparam int          STUCK_LIMIT = 5000;
  localparam logic [63:0] PNG_MAGIC   = 64'h8950_4E47_0D0A_1A0A;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic [ByteW-1:0] in_byte   = '0;
  logic             out_stall = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_data  = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic             cfg_ready;
  logic [1:0]       kind;
  logic [ByteW-1:0] message_byte;
  logic [WordW-1:0] chunk_length;
  logic [WordW-1:0] type_word;
  logic [WordW-1:0] crc_word;
  logic             known_type;
  logic             final_chunk;

  int fails;
  int waiting;
  int msg_total;
  int summary_total;
  int error_total;
  int gap_pct    = 0;
  int stall_pct  = 0;
  int sent_bytes = 0;
  int emit_writes = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  png_chunk_stream_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .message_byte (message_byte),
    .chunk_length (chunk_length),
    .type_word    (type_word),
    .crc_word     (crc_word),
    .known_type   (known_type),
    .final_chunk  (final_chunk),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  png_chunk_stream_parser_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .message_byte  (message_byte),
    .chunk_length  (chunk_length),
    .type_word     (type_word),
    .crc_word      (crc_word),
    .known_type    (known_type),
    .final_chunk   (final_chunk),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fails         (fails),
    .waiting       (waiting),
    .msg_total     (msg_total),
    .summary_total (summary_total),
    .error_total   (error_total)
  );

  always @(posedge clk)
    out_stall <= ($urandom_range(0, 99) < stall_pct);

  task automatic put_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic put_word(input logic [WordW-1:0] w);
    put_byte(w[31:24]);
    put_byte(w[23:16]);
    put_byte(w[15:8]);
    put_byte(w[7:0]);
  endtask

  function automatic logic [ByteW-1:0] data_byte();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // IEND is left out here: it ends the stream and is sent only at the close.
  function automatic logic [WordW-1:0] pick_chunk_type();
    logic [WordW-1:0] t;
    int               sel;
    int               k;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      t = TYPE_IHDR;
    end else if (sel < 4) begin
      t = TYPE_IDAT;
    end else if (sel < 7) begin
      for (k = 0; k < 4; k++)
        t = {t[23:0], 8'($urandom_range(0, 1) ? 65 + $urandom_range(0, 25)
                                              : 97 + $urandom_range(0, 25))};
    end else if (sel < 9) begin
      t = $urandom;
    end else begin
      // near miss of a standard type
      case ($urandom_range(0, 2))
        0:       t = TYPE_IHDR;
        1:       t = TYPE_IDAT;
        default: t = TYPE_IEND;
      endcase
      t = t ^ (32'd1 << $urandom_range(0, 31));
    end
    if (t == TYPE_IEND) t = t ^ 32'd1;
    return t;
  endfunction

  task automatic put_chunk(input logic [WordW-1:0] typ, input int len);
    int i;
    put_word(len);
    put_word(typ);
    for (i = 0; i < len; i++) put_byte(data_byte());
    put_word($urandom);
  endtask

  // Hold input until every pending result is out, then let the pipe settle.
  task automatic drain_parser();
    in_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_emit(input logic v);
    drain_parser();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    emit_writes++;
  endtask

  task automatic set_idling(input int mix);
    case (mix)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 48; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 48; end
      default: begin gap_pct = 7; stall_pct = 7; end
    endcase
  endtask

  initial begin : stim
    logic [63:0] sig;
    logic        corrupt;
    logic        emit_val;
    int          mix;
    int          next_mix_at;
    int          next_cfg_at;
    int          i;
    sig = PNG_MAGIC;
    corrupt = ($urandom_range(0, 9) == 0);
    if (corrupt) sig[8*$urandom_range(0, 7) + $urandom_range(0, 7)] ^= 1'b1;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_emit(1'b1);

    for (i = 0; i < 8; i++) put_byte(sig[63 - 8*i -: 8]);
    if (corrupt) begin
      // everything after a bad signature must be swallowed
      write_emit(1'b0);
      for (i = 0; i < 40; i++) put_byte(8'($urandom));
      write_emit(1'b1);
      mix = 0;
      next_mix_at = sent_bytes + 60;
      while (sent_bytes < 400) begin
        if (sent_bytes >= next_mix_at) begin
          mix = (mix + 1) % 4;
          set_idling(mix);
          next_mix_at += 60;
        end
        put_byte(data_byte());
      end
    end else begin
      // empty chunk, then one with data at both byte extremes
      put_word(32'd0);
      put_word(32'h7445_5874);
      put_word(32'hFFFF_FFFF);
      put_word(32'd2);
      put_word(32'h7A54_5874);
      put_byte(8'h00);
      put_byte(8'hFF);
      put_word(32'h0000_0000);

      write_emit(1'b0);
      emit_val = 1'b0;
      mix = 0;
      next_mix_at = sent_bytes + 60;
      next_cfg_at = sent_bytes + 110;
      while (sent_bytes < 400) begin
        if (sent_bytes >= next_mix_at) begin
          mix = (mix + 1) % 4;
          set_idling(mix);
          next_mix_at += 60;
        end
        if (sent_bytes >= next_cfg_at) begin
          emit_val = !emit_val;
          write_emit(emit_val);
          next_cfg_at += 110;
        end
        put_chunk(pick_chunk_type(), ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                                 : $urandom_range(0, 12));
      end
      put_chunk(TYPE_IEND, $urandom_range(0, 3));
      // 16 bytes after the end must give nothing
      for (i = 0; i < 16; i++) put_byte(data_byte());
    end

    drain_parser();
    repeat (6) @(posedge clk);
    $display("stream of %0d bytes (%s signature), %0d emit writes, four idling mixes",
             sent_bytes, corrupt ? "corrupted" : "valid", emit_writes);
    $display("results checked: %0d message bytes, %0d chunk summaries, %0d signature errors",
             msg_total, summary_total, error_total);
    if (fails == 0 && waiting == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("watchdog: no request moved for %0d cycles", STUCK_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
